>>> design/fme7_pkg.sv
// shared types and constants for the bank mapper with scanline interrupt
`timescale 1ns / 1ps

package fme7_pkg;

  localparam int unsigned CountShift = 8;
  localparam int unsigned LineStep   = 29099;

  localparam int unsigned CntW   = 24;
  localparam int unsigned ChrW   = 11;
  localparam int unsigned PrgW   = 9;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned DataW  = 8;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned MirW   = 2;
  localparam int unsigned CmdW   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StepW  = $clog2(DataW);

  localparam logic [CntW-1:0] IrqLimit = CntW'(LineStep + LineStep / 16);
  localparam logic [CntW-1:0] LineStepC = CntW'(LineStep);

  localparam logic OP_CPU_WRITE = 1'b0;
  localparam logic OP_TICK      = 1'b1;

  localparam logic [2:0] ADDR_SELECT  = 3'b100;
  localparam logic [2:0] ADDR_EXECUTE = 3'b101;

  localparam logic [CmdW-1:0] CMD_LAST_CHR = 4'd7;
  localparam logic [CmdW-1:0] CMD_WINDOW   = 4'd8;
  localparam logic [CmdW-1:0] CMD_LAST_PRG = 4'd11;
  localparam logic [CmdW-1:0] CMD_MIRROR   = 4'd12;
  localparam logic [CmdW-1:0] CMD_IRQ_EN   = 4'd13;
  localparam logic [CmdW-1:0] CMD_CNT_LO   = 4'd14;
  localparam logic [CmdW-1:0] CMD_CNT_HI   = 4'd15;

  localparam logic [CfgIdxW-1:0] REG_CHR_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PRG_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SUBMAPPER = 2'd2;

  localparam logic [15:0] KEEP_HIGH = 16'hff00;
  localparam logic [15:0] KEEP_LOW  = 16'h00ff;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } fme7_state_e;

endpackage

>>> design/fme7_if.sv
// handshake channels for input and result words
`timescale 1ns / 1ps

interface fme7_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [fme7_pkg::AddrW-1:0]    address;
  logic [fme7_pkg::DataW-1:0]    data;

  modport source (output valid, operation, address, data, input ready);
  modport sink   (input valid, operation, address, data, output ready);
endinterface

interface fme7_out_if;
  logic                          valid;
  logic                          ready;
  logic                          bank_update;
  logic [fme7_pkg::SlotW-1:0]    bank_slot;
  logic [fme7_pkg::DataW-1:0]    bank_page;
  logic [fme7_pkg::MirW-1:0]     mirror_mode;
  logic                          irq_request;

  modport source (output valid, bank_update, bank_slot, bank_page, mirror_mode, irq_request,
                  input ready);
  modport sink   (input valid, bank_update, bank_slot, bank_page, mirror_mode, irq_request,
                  output ready);
endinterface

>>> design/fme7_bank_mapper_irq_unit.sv
// top level: bank mapper command decoder, scanline interrupt counter, serial modulo unit
//
// in_ch carries one word per cpu write or scanline tick; out_ch returns exactly one
// result word per input word. cfg_we_i / cfg_index_i / cfg_data_i write the pattern
// page count, program page count and submapper flag; the user must write them only
// while the block is idle, as the block itself does not enforce it. state, mirroring
// and the interrupt counter are updated at the edge a word is taken. a bank command
// with a nonzero page count runs the page modulo through one shared restoring
// subtract unit, one data bit per cycle. every word then waits in the result stage
// until the output register is loaded. ready is low while busy, so a new word is
// taken only after the last one has loaded the output register.
// the output register holds a result while out_ch.ready is low; the next word is
// still accepted and waits in the result stage until the register frees up.
// reset clears the command, enable, counter, mirroring, configuration and valid flags.
`timescale 1ns / 1ps

module fme7_bank_mapper_irq_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fme7_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [fme7_pkg::ChrW-1:0]       cfg_data_i,
  fme7_in_if.sink                         in_ch,
  fme7_out_if.source                      out_ch
);

  fme7_pkg::fme7_state_e state_q, state_d;

  logic [fme7_pkg::ChrW-1:0]   chr_cnt_q;
  logic [fme7_pkg::PrgW-1:0]   prg_cnt_q;
  logic                        sub_q;

  logic [fme7_pkg::CmdW-1:0]   cmd_q, cmd_d;
  logic                        irq_en_q, irq_en_d;
  logic [fme7_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [fme7_pkg::MirW-1:0]   mirror_q, mirror_d;

  logic [fme7_pkg::StepW-1:0]  step_q, step_d;
  logic [fme7_pkg::ChrW-1:0]   rem_q, rem_d;
  logic [fme7_pkg::DataW-1:0]  dvd_q, dvd_d;
  logic [fme7_pkg::ChrW-1:0]   div_q, div_d;
  logic                        res_upd_q, res_upd_d;
  logic [fme7_pkg::SlotW-1:0]  res_slot_q, res_slot_d;
  logic                        res_irq_q, res_irq_d;

  logic                        out_valid_q;
  logic                        out_upd_q;
  logic [fme7_pkg::SlotW-1:0]  out_slot_q;
  logic [fme7_pkg::DataW-1:0]  out_page_q;
  logic [fme7_pkg::MirW-1:0]   out_mirror_q;
  logic                        out_irq_q;

  logic                        in_ready;
  logic                        accept;
  logic                        load_out;
  logic                        div_last;

  logic                        bank_cmd;
  logic                        need_div;
  logic [fme7_pkg::ChrW-1:0]   divisor;
  logic [15:0]                 unscaled;
  logic [15:0]                 merged;

  logic [fme7_pkg::ChrW:0]     trial;
  logic                        trial_ge;

  // control outputs
  always_comb begin
    in_ready = (state_q == fme7_pkg::ST_IDLE);
    load_out = (state_q == fme7_pkg::ST_DONE) && (!out_valid_q || out_ch.ready);
    div_last = (state_q == fme7_pkg::ST_DIV) && (step_q == '0);
  end

  assign accept       = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fme7_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = need_div ? fme7_pkg::ST_DIV : fme7_pkg::ST_DONE;
        end
      end
      fme7_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = fme7_pkg::ST_DONE;
        end
      end
      fme7_pkg::ST_DONE: begin
        if (load_out) begin
          state_d = fme7_pkg::ST_IDLE;
        end
      end
      default: state_d = fme7_pkg::ST_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    bank_cmd = 1'b0;
    divisor  = '0;
    if (cmd_q <= fme7_pkg::CMD_LAST_CHR) begin
      bank_cmd = 1'b1;
      divisor  = chr_cnt_q;
    end else if (cmd_q == fme7_pkg::CMD_WINDOW) begin
      bank_cmd = !sub_q && !in_ch.data[6];
      divisor  = fme7_pkg::ChrW'(prg_cnt_q);
    end else if (cmd_q <= fme7_pkg::CMD_LAST_PRG) begin
      bank_cmd = 1'b1;
      divisor  = fme7_pkg::ChrW'(prg_cnt_q);
    end
    need_div = (in_ch.operation == fme7_pkg::OP_CPU_WRITE)
               && (in_ch.address[15:13] == fme7_pkg::ADDR_EXECUTE)
               && bank_cmd && (divisor != '0);
  end

  // counter byte merge
  always_comb begin
    unscaled = 16'(cnt_q >> fme7_pkg::CountShift);
    if (cmd_q == fme7_pkg::CMD_CNT_LO) begin
      merged = (unscaled & fme7_pkg::KEEP_HIGH) | 16'(in_ch.data);
    end else begin
      merged = (unscaled & fme7_pkg::KEEP_LOW) | {in_ch.data, 8'h00};
    end
  end

  // shared restoring subtract step
  always_comb begin
    trial    = {rem_q, dvd_q[fme7_pkg::DataW-1]};
    trial_ge = (trial >= {1'b0, div_q});
  end

  // datapath
  always_comb begin
    cmd_d      = cmd_q;
    irq_en_d   = irq_en_q;
    cnt_d      = cnt_q;
    mirror_d   = mirror_q;
    step_d     = step_q;
    rem_d      = rem_q;
    dvd_d      = dvd_q;
    div_d      = div_q;
    res_upd_d  = res_upd_q;
    res_slot_d = res_slot_q;
    res_irq_d  = res_irq_q;

    if (accept) begin
      res_upd_d  = need_div;
      res_slot_d = need_div ? cmd_q : '0;
      res_irq_d  = 1'b0;
      rem_d      = '0;
      dvd_d      = in_ch.data;
      div_d      = divisor;
      step_d     = fme7_pkg::StepW'(fme7_pkg::DataW - 1);
      if (in_ch.operation == fme7_pkg::OP_TICK) begin
        if (irq_en_q) begin
          if (cnt_q <= fme7_pkg::IrqLimit) begin
            res_irq_d = 1'b1;
            cnt_d     = '0;
            irq_en_d  = 1'b0;
          end else begin
            cnt_d = cnt_q - fme7_pkg::LineStepC;
          end
        end
      end else if (in_ch.address[15:13] == fme7_pkg::ADDR_SELECT) begin
        cmd_d = in_ch.data[fme7_pkg::CmdW-1:0];
      end else if (in_ch.address[15:13] == fme7_pkg::ADDR_EXECUTE) begin
        case (cmd_q)
          fme7_pkg::CMD_MIRROR: mirror_d = in_ch.data[fme7_pkg::MirW-1:0];
          fme7_pkg::CMD_IRQ_EN: irq_en_d = (in_ch.data != '0);
          fme7_pkg::CMD_CNT_LO,
          fme7_pkg::CMD_CNT_HI: begin
            cnt_d = fme7_pkg::CntW'(32'(merged) << fme7_pkg::CountShift);
          end
          default: ;
        endcase
      end
    end else if (state_q == fme7_pkg::ST_DIV) begin
      rem_d  = trial_ge ? fme7_pkg::ChrW'(trial - {1'b0, div_q}) : trial[fme7_pkg::ChrW-1:0];
      dvd_d  = {dvd_q[fme7_pkg::DataW-2:0], 1'b0};
      step_d = step_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fme7_pkg::ST_IDLE;
      chr_cnt_q   <= '0;
      prg_cnt_q   <= '0;
      sub_q       <= 1'b0;
      cmd_q       <= '0;
      irq_en_q    <= 1'b0;
      cnt_q       <= '0;
      mirror_q    <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      irq_en_q <= irq_en_d;
      cnt_q    <= cnt_d;
      mirror_q <= mirror_d;
      step_q   <= step_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          fme7_pkg::REG_CHR_COUNT: chr_cnt_q <= cfg_data_i;
          fme7_pkg::REG_PRG_COUNT: prg_cnt_q <= cfg_data_i[fme7_pkg::PrgW-1:0];
          fme7_pkg::REG_SUBMAPPER: sub_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    div_q      <= div_d;
    res_upd_q  <= res_upd_d;
    res_slot_q <= res_slot_d;
    res_irq_q  <= res_irq_d;
    if (load_out) begin
      out_upd_q    <= res_upd_q;
      out_slot_q   <= res_slot_q;
      out_page_q   <= rem_q[fme7_pkg::DataW-1:0];
      out_mirror_q <= mirror_q;
      out_irq_q    <= res_irq_q;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.bank_update = out_upd_q;
  assign out_ch.bank_slot   = out_slot_q;
  assign out_ch.bank_page   = out_page_q;
  assign out_ch.mirror_mode = out_mirror_q;
  assign out_ch.irq_request = out_irq_q;

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != fme7_pkg::ST_IDLE))
    else $error("accepted word did not start work");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fme7_pkg::ST_DIV) |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

  a_irq_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && res_irq_q) |-> (!irq_en_q && (cnt_q == '0)))
    else $error("interrupt raised without clearing enable and counter");

  a_no_update_zero_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && !res_upd_q) |-> (rem_q == '0) && (res_slot_q == '0))
    else $error("idle bank fields not zero");
`endif

endmodule

>>> test/fme7_bank_mapper_irq_unit_test.sv
// testbench for the bank mapper with scanline interrupt: directed table, random sequences
`timescale 1ns / 1ps

module fme7_bank_mapper_irq_unit_test;

  localparam int unsigned CntBits = fme7_pkg::CntW;
  localparam logic [fme7_pkg::CntW-1:0] TickLimit =
    fme7_pkg::CntW'(fme7_pkg::LineStep + fme7_pkg::LineStep / 16);
  localparam logic [fme7_pkg::CntW-1:0] TickStep = fme7_pkg::CntW'(fme7_pkg::LineStep);
  localparam int unsigned PhaseWords = 170;
  localparam int ChrPlan [6] = '{2040, 1, 255, 0, 256, 0};
  localparam int PrgPlan [6] = '{510, 1, 0, 255, 3, 0};
  localparam int SubPlan [6] = '{0, 1, 0, 1, 0, 0};

  typedef struct packed {
    logic                       bank_update;
    logic [fme7_pkg::SlotW-1:0] bank_slot;
    logic [fme7_pkg::DataW-1:0] bank_page;
    logic [fme7_pkg::MirW-1:0]  mirror_mode;
    logic                       irq_request;
  } mapper_result_t;

  typedef enum logic {ROW_WORD, ROW_SETTING} row_kind_e;

  typedef struct {
    row_kind_e      kind;
    logic           op;
    logic [15:0]    addr;
    logic [7:0]     data;
    int             chr;
    int             prg;
    int             sub;
    bit             known;
    mapper_result_t want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [fme7_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [fme7_pkg::ChrW-1:0] cfg_data_i;

  fme7_in_if in_ch ();
  fme7_out_if out_ch ();

  fme7_bank_mapper_irq_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // predictor state and configuration copy
  logic [fme7_pkg::CmdW-1:0] cmd_sel = '0;
  logic irq_armed = 1'b0;
  logic [fme7_pkg::CntW-1:0] irq_count = '0;
  logic [fme7_pkg::MirW-1:0] mirror_now = '0;
  logic [fme7_pkg::ChrW-1:0] chr_pages = '0;
  logic [fme7_pkg::PrgW-1:0] prg_pages = '0;
  logic sub_one = 1'b0;

  mapper_result_t pending_results[$];
  plan_row_t plan[$];
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned updates_seen = 0;
  int unsigned irqs_seen = 0;
  int unsigned settings_applied = 0;
  int unsigned mismatches = 0;
  bit calm = 1'b0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic mapper_result_t step_mapper(input logic op, input logic [15:0] addr,
                                                 input logic [7:0] d);
    mapper_result_t r;
    logic [31:0] unscaled;
    r = '0;
    unscaled = '0;
    if (op == fme7_pkg::OP_TICK) begin
      if (irq_armed) begin
        if (irq_count <= TickLimit) begin
          r.irq_request = 1'b1;
          irq_count = '0;
          irq_armed = 1'b0;
        end else begin
          irq_count = irq_count - TickStep;
        end
      end
    end else if (addr[15:13] == fme7_pkg::ADDR_SELECT) begin
      cmd_sel = d[3:0];
    end else if (addr[15:13] == fme7_pkg::ADDR_EXECUTE) begin
      if (cmd_sel <= fme7_pkg::CMD_LAST_CHR) begin
        if (chr_pages != 0) begin
          r.bank_update = 1'b1;
          r.bank_slot = cmd_sel;
          r.bank_page = 8'(32'(d) % 32'(chr_pages));
        end
      end else if (cmd_sel == fme7_pkg::CMD_WINDOW) begin
        if (!sub_one && !d[6] && prg_pages != 0) begin
          r.bank_update = 1'b1;
          r.bank_slot = cmd_sel;
          r.bank_page = 8'(32'(d) % 32'(prg_pages));
        end
      end else if (cmd_sel <= fme7_pkg::CMD_LAST_PRG) begin
        if (prg_pages != 0) begin
          r.bank_update = 1'b1;
          r.bank_slot = cmd_sel;
          r.bank_page = 8'(32'(d) % 32'(prg_pages));
        end
      end else if (cmd_sel == fme7_pkg::CMD_MIRROR) begin
        mirror_now = d[1:0];
      end else if (cmd_sel == fme7_pkg::CMD_IRQ_EN) begin
        irq_armed = (d != 0);
      end else if (cmd_sel == fme7_pkg::CMD_CNT_LO) begin
        unscaled = ((32'(irq_count) >> fme7_pkg::CountShift) & 32'(fme7_pkg::KEEP_HIGH))
                   | 32'(d);
        unscaled = unscaled << fme7_pkg::CountShift;
        irq_count = unscaled[CntBits-1:0];
      end else begin
        unscaled = ((32'(irq_count) >> fme7_pkg::CountShift) & 32'(fme7_pkg::KEEP_LOW))
                   | (32'(d) << 8);
        unscaled = unscaled << fme7_pkg::CountShift;
        irq_count = unscaled[CntBits-1:0];
      end
    end
    r.mirror_mode = mirror_now;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic plan_row_t row_word(input logic op, input logic [15:0] a,
                                         input logic [7:0] d);
    plan_row_t r;
    r = '{ROW_WORD, op, a, d, 0, 0, 0, 1'b0, '0};
    return r;
  endfunction

  function automatic plan_row_t row_known(input logic op, input logic [15:0] a,
                                          input logic [7:0] d, input int upd,
                                          input int slot, input int page,
                                          input int mir, input int irq);
    plan_row_t r;
    r = '{ROW_WORD, op, a, d, 0, 0, 0, 1'b1,
          '{1'(upd), 4'(slot), 8'(page), 2'(mir), 1'(irq)}};
    return r;
  endfunction

  function automatic plan_row_t row_setting(input int chr, input int prg, input int sub);
    plan_row_t r;
    r = '{ROW_SETTING, fme7_pkg::OP_CPU_WRITE, 16'h0, 8'h0, chr, prg, sub, 1'b0, '0};
    return r;
  endfunction

  // entered and left at a falling edge; valid stays high into the next word when no gap
  task automatic send_word(input logic op, input logic [15:0] a, input logic [7:0] d,
                           input bit known, input mapper_result_t want);
    mapper_result_t predicted;
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.address <= a;
    in_ch.data <= d;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = step_mapper(op, a, d);
    pending_results.push_back(known ? want : predicted);
    words_sent++;
    @(negedge clk_i);
    gap = calm ? 0 : gap_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic put(input logic op, input logic [15:0] a, input logic [7:0] d);
    send_word(op, a, d, 1'b0, '0);
  endtask

  task automatic select_cmd(input logic [3:0] c);
    put(fme7_pkg::OP_CPU_WRITE, {fme7_pkg::ADDR_SELECT, 13'($urandom)}, {4'($urandom), c});
  endtask

  task automatic exec_cmd(input logic [7:0] d);
    put(fme7_pkg::OP_CPU_WRITE, {fme7_pkg::ADDR_EXECUTE, 13'($urandom)}, d);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic apply_setting(input int chr, input int prg, input int sub);
    cfg_we_i <= 1'b1;
    cfg_index_i <= fme7_pkg::REG_CHR_COUNT;
    cfg_data_i <= fme7_pkg::ChrW'(chr);
    @(negedge clk_i);
    cfg_index_i <= fme7_pkg::REG_PRG_COUNT;
    cfg_data_i <= fme7_pkg::ChrW'(prg);
    @(negedge clk_i);
    cfg_index_i <= fme7_pkg::REG_SUBMAPPER;
    cfg_data_i <= fme7_pkg::ChrW'(sub);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    chr_pages = fme7_pkg::ChrW'(chr);
    prg_pages = fme7_pkg::PrgW'(prg);
    sub_one = sub[0];
    settings_applied++;
  endtask

  function automatic logic [7:0] pick_low();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'd120;
    if (r < 40) return 8'd121;
    if (r < 55) return 8'hff;
    if (r < 65) return 8'h00;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_high();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(0, 12));
    if (r < 70) return 8'h00;
    if (r < 90) return 8'($urandom_range(13, 60));
    return 8'($urandom);
  endfunction

  task automatic run_episode();
    int unsigned kind;
    int unsigned ticks;
    kind = $urandom_range(0, 99);
    calm = ($urandom_range(0, 9) == 0);
    if (kind < 35) begin
      select_cmd(fme7_pkg::CMD_CNT_LO);
      exec_cmd(pick_low());
      select_cmd(fme7_pkg::CMD_CNT_HI);
      exec_cmd(pick_high());
      select_cmd(fme7_pkg::CMD_IRQ_EN);
      exec_cmd(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      ticks = 0;
      while (irq_armed && ticks < 80) begin
        if ($urandom_range(0, 9) == 0) begin
          select_cmd(4'($urandom_range(0, 11)));
          exec_cmd(8'($urandom));
        end
        put(fme7_pkg::OP_TICK, 16'($urandom), 8'($urandom));
        ticks++;
      end
      repeat ($urandom_range(0, 2)) put(fme7_pkg::OP_TICK, 16'($urandom), 8'($urandom));
    end else if (kind < 70) begin
      select_cmd(4'($urandom_range(0, 11)));
      repeat ($urandom_range(1, 3)) exec_cmd(8'($urandom));
    end else if (kind < 78) begin
      select_cmd(fme7_pkg::CMD_MIRROR);
      exec_cmd(8'($urandom));
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 4)) put(1'($urandom), 16'($urandom), 8'($urandom));
    end else begin
      exec_cmd(8'($urandom));
      put(fme7_pkg::OP_TICK, 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin : sink_pacing
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 30) stall_left = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    mapper_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (out_ch.bank_update) updates_seen++;
        if (out_ch.irq_request) irqs_seen++;
        if (out_ch.bank_update !== want.bank_update) begin
          $error("bank_update: expected %0d, got %0d", want.bank_update, out_ch.bank_update);
          mismatches++;
        end
        if (out_ch.bank_slot !== want.bank_slot) begin
          $error("bank_slot: expected %0d, got %0d", want.bank_slot, out_ch.bank_slot);
          mismatches++;
        end
        if (out_ch.bank_page !== want.bank_page) begin
          $error("bank_page: expected %0d, got %0d", want.bank_page, out_ch.bank_page);
          mismatches++;
        end
        if (out_ch.mirror_mode !== want.mirror_mode) begin
          $error("mirror_mode: expected %0d, got %0d", want.mirror_mode, out_ch.mirror_mode);
          mismatches++;
        end
        if (out_ch.irq_request !== want.irq_request) begin
          $error("irq_request: expected %0d, got %0d", want.irq_request, out_ch.irq_request);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("fme7_bank_mapper_irq_unit_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    plan_row_t row;
    int unsigned phase_start;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = fme7_pkg::OP_CPU_WRITE;
    in_ch.address = '0;
    in_ch.data = '0;

    plan.push_back(row_known(fme7_pkg::OP_TICK, 16'hffff, 8'hff, 0, 0, 0, 0, 0));
    plan.push_back(row_known(fme7_pkg::OP_CPU_WRITE, 16'h8000, 8'h00, 0, 0, 0, 0, 0));
    plan.push_back(row_known(fme7_pkg::OP_CPU_WRITE, 16'ha000, 8'hff, 0, 0, 0, 0, 0));
    plan.push_back(row_known(fme7_pkg::OP_CPU_WRITE, 16'h7fff, 8'hff, 0, 0, 0, 0, 0));
    plan.push_back(row_known(fme7_pkg::OP_CPU_WRITE, 16'hc000, 8'hff, 0, 0, 0, 0, 0));
    plan.push_back(row_known(fme7_pkg::OP_CPU_WRITE, 16'h9fff, 8'hfc, 0, 0, 0, 0, 0));
    plan.push_back(row_known(fme7_pkg::OP_CPU_WRITE, 16'hbfff, 8'hff, 0, 0, 0, 3, 0));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'h8000, 8'h0e));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'ha000, 8'h00));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'h8000, 8'h0f));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'ha000, 8'h00));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'h8000, 8'h0d));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'ha000, 8'h80));
    plan.push_back(row_known(fme7_pkg::OP_TICK, 16'h0000, 8'h00, 0, 0, 0, 3, 1));
    plan.push_back(row_known(fme7_pkg::OP_TICK, 16'hffff, 8'hff, 0, 0, 0, 3, 0));
    plan.push_back(row_setting(2040, 510, 0));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'h8000, 8'h08));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'ha000, 8'hbf));
    plan.push_back(row_known(fme7_pkg::OP_CPU_WRITE, 16'ha000, 8'h40, 0, 0, 0, 3, 0));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'h8000, 8'hf7));
    plan.push_back(row_known(fme7_pkg::OP_CPU_WRITE, 16'ha000, 8'hff, 1, 7, 255, 3, 0));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'h8000, 8'h0b));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'hbfff, 8'h00));
    plan.push_back(row_setting(1, 1, 1));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'h8000, 8'h08));
    plan.push_back(row_known(fme7_pkg::OP_CPU_WRITE, 16'ha000, 8'h00, 0, 0, 0, 3, 0));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'h8000, 8'h09));
    plan.push_back(row_word(fme7_pkg::OP_CPU_WRITE, 16'ha000, 8'hff));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_SETTING) begin
        settle();
        apply_setting(row.chr, row.prg, row.sub);
      end else begin
        send_word(row.op, row.addr, row.data, row.known, row.want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      settle();
      if (p == 5) begin
        apply_setting($urandom_range(0, 2040), $urandom_range(0, 510), $urandom_range(0, 1));
      end else begin
        apply_setting(ChrPlan[p], PrgPlan[p], SubPlan[p]);
      end
      phase_start = words_sent;
      while (words_sent - phase_start < PhaseWords) run_episode();
    end
    settle();

    $display("sent %0d words over %0d register settings, checked %0d results",
             words_sent, settings_applied, words_checked);
    $display("bank updates seen %0d, interrupts seen %0d", updates_seen, irqs_seen);
    if (mismatches == 0) begin
      $display("fme7_bank_mapper_irq_unit_test OK");
    end else begin
      $display("fme7_bank_mapper_irq_unit_test NOT OK");
    end
    $finish;
  end

endmodule
